[design/eph_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package eph_pkg;

    // input beat: one sensor tick
    typedef struct packed {
        logic signed [15:0] target_distance;
        logic               encoder_level;
        logic               home_switch_level;
        logic        [11:0] hall_sample;
    } sample_t;

    // output beat: status after the tick
    typedef struct packed {
        logic        [1:0]  mode;
        logic        [7:0]  up_duty;
        logic        [7:0]  down_duty;
        logic        [7:0]  step_count;
        logic signed [11:0] goal_count;
    } result_t;

    // positioner modes, one-hot
    typedef enum logic [3:0] {
        ST_WAIT    = 4'b0001,
        ST_MOVE    = 4'b0010,
        ST_REACHED = 4'b0100,
        ST_HOME    = 4'b1000
    } mode_st_t;

    // motor drive direction
    typedef enum logic [1:0] {
        DIR_STOP = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    // mode codes as seen on the result beat
    localparam logic [1:0] MODE_WAIT    = 2'd0;
    localparam logic [1:0] MODE_MOVE    = 2'd1;
    localparam logic [1:0] MODE_REACHED = 2'd2;
    localparam logic [1:0] MODE_HOME    = 2'd3;

    // configuration register indexes
    localparam int         CFG_IDX_W          = 2;
    localparam int         CFG_DATA_W         = 12;
    localparam logic [1:0] REG_HALL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_STEP_LIMIT     = 2'd1;
    localparam logic [1:0] REG_MOTOR_DUTY     = 2'd2;

    // configuration reset values
    localparam logic [11:0] HALL_THRESHOLD_RST = 12'd30;
    localparam logic [7:0]  STEP_LIMIT_RST     = 8'd44;
    localparam logic [7:0]  MOTOR_DUTY_RST     = 8'd200;

    // goal = round(11 * (v - 360) / 612), half away from zero
    // 360 is 22.5 in Q12.4; x / 612 is (x >> 2) / 153
    localparam logic signed [16:0] GOAL_OFFSET = 17'sd360;
    localparam logic [19:0]        GOAL_ROUND  = 20'd306;
    // ceil(2^25 / 153), exact for a 17-bit dividend
    localparam int                 RECIP_SHIFT = 25;
    localparam logic [17:0]        GOAL_RECIP  = 18'd219311;

endpackage

`default_nettype wire

[design/encoder_positioner_with_homing.sv]
`timescale 1ns / 1ps
`default_nettype none

// Encoder positioner with homing.
// Input channel sample/sample_valid/sample_stall carries one sensor tick per
// beat: distance command, encoder and switch levels, hall reading. Output
// channel result/result_valid/result_stall returns one status beat per tick:
// mode, up and down duty, step count and goal.
// Configuration: cfg_write with cfg_index 0 hall threshold, 1 step limit,
// 2 motor duty; other indexes are ignored. Write only while the block is idle.
// The work runs through three registers: input, goal (constant-scaled
// reciprocal multiply) and the state update feeding the result register.
// A beat accepted into the input register passes through the goal register to
// result, and one beat per cycle is sustained while result_stall is low.
// Reset empties the pipe, puts the positioner in homing with the motor
// stopped and loads the default thresholds and duty.
// When result_stall is high the result holds; the pipe keeps filling and
// sample_stall rises only once all three stages are full.
module encoder_positioner_with_homing
    import eph_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  sample_valid,
    output      logic                  sample_stall,
    input  wire sample_t               sample,
    output      logic                  result_valid,
    input  wire logic                  result_stall,
    output      result_t               result
);

    // configuration registers
    logic [11:0] hall_threshold_reg;
    logic [7:0]  step_limit_reg;
    logic [7:0]  motor_duty_reg;

    // pipeline control
    logic    in_valid_reg;
    logic    goal_valid_reg;
    logic    out_valid_reg;
    logic    out_ready;
    logic    goal_ready;
    logic    in_ready;
    logic    goal_move;
    logic    in_move;
    logic    in_take;

    // pipeline payload
    sample_t            in_data_reg;
    sample_t            goal_data_reg;
    logic signed [11:0] goal_calc_reg;
    result_t            result_reg;
    result_t            result_next;

    // goal arithmetic
    logic signed [16:0] diff;
    logic signed [20:0] diff_x;
    logic signed [20:0] scaled;
    logic        [20:0] scaled_neg;
    logic        [19:0] mag;
    logic        [19:0] mag_rnd;
    logic        [16:0] quot_in;
    logic        [34:0] prod;
    logic        [11:0] quot;
    logic signed [11:0] goal_calc_next;

    // positioner state
    mode_st_t           mode_st_reg;
    mode_st_t           mode_st_next;
    logic               last_encoder_reg;
    logic               last_encoder_next;
    logic               last_switch_reg;
    logic               last_switch_next;
    logic        [7:0]  steps_done_reg;
    logic        [7:0]  steps_done_next;
    logic signed [11:0] target_steps_reg;
    logic signed [11:0] target_steps_next;
    dir_t               drive_dir_reg;
    dir_t               drive_dir_next;
    logic               zero_cmd;
    logic [1:0]         mode_code;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hall_threshold_reg <= HALL_THRESHOLD_RST;
            step_limit_reg     <= STEP_LIMIT_RST;
            motor_duty_reg     <= MOTOR_DUTY_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HALL_THRESHOLD: hall_threshold_reg <= cfg_data;
                REG_STEP_LIMIT:     step_limit_reg     <= cfg_data[7:0];
                REG_MOTOR_DUTY:     motor_duty_reg     <= cfg_data[7:0];
                default:            ;
            endcase
        end
    end

    // elastic handshake through the three stages
    assign out_ready    = !out_valid_reg || !result_stall;
    assign goal_ready   = !goal_valid_reg || out_ready;
    assign in_ready     = !in_valid_reg || goal_ready;
    assign goal_move    = goal_valid_reg && out_ready;
    assign in_move      = in_valid_reg && goal_ready;
    assign in_take      = sample_valid && in_ready;
    assign sample_stall = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            goal_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= sample_valid;
            end
            if (goal_ready)
            begin
                goal_valid_reg <= in_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= goal_valid_reg;
            end
        end
    end

    // goal stage: 11 * (v - 360), magnitude, round, divide by 612
    always_comb
    begin
        diff           = {in_data_reg.target_distance[15], in_data_reg.target_distance}
                         - GOAL_OFFSET;
        diff_x         = {{4{diff[16]}}, diff};
        scaled         = (diff_x <<< 3) + (diff_x <<< 1) + diff_x;
        scaled_neg     = 21'd0 - scaled;
        mag            = scaled[20] ? scaled_neg[19:0] : scaled[19:0];
        mag_rnd        = mag + GOAL_ROUND;
        quot_in        = mag_rnd[18:2];
        prod           = {18'd0, quot_in} * {17'd0, GOAL_RECIP};
        quot           = {2'b00, prod[34:RECIP_SHIFT]};
        goal_calc_next = scaled[20] ? $signed(12'd0 - quot) : $signed(quot);
    end

    // payload registers of the first two stages
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= sample;
        end
        if (in_move)
        begin
            goal_data_reg <= in_data_reg;
            goal_calc_reg <= goal_calc_next;
        end
    end

    // positioner update for the beat in the goal stage
    always_comb
    begin
        zero_cmd          = (goal_data_reg.target_distance == 16'sd0);
        mode_st_next      = mode_st_reg;
        last_encoder_next = last_encoder_reg;
        last_switch_next  = last_switch_reg;
        steps_done_next   = steps_done_reg;
        target_steps_next = target_steps_reg;
        drive_dir_next    = drive_dir_reg;
        if (!(zero_cmd && mode_st_reg == ST_WAIT))
        begin
            last_encoder_next = goal_data_reg.encoder_level;
            case (mode_st_reg)
                ST_WAIT:
                begin
                    target_steps_next = goal_calc_reg;
                    mode_st_next      = ST_MOVE;
                end
                ST_MOVE:
                begin
                    if ($signed({4'b0000, steps_done_reg}) < target_steps_reg)
                    begin
                        drive_dir_next = DIR_UP;
                        if (goal_data_reg.encoder_level && !last_encoder_reg
                            && steps_done_reg != 8'hFF)
                        begin
                            steps_done_next = steps_done_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        drive_dir_next = DIR_STOP;
                        mode_st_next   = ST_REACHED;
                    end
                    // early stop on low hall reading or too many steps
                    if (goal_data_reg.hall_sample < hall_threshold_reg
                        || steps_done_next > step_limit_reg)
                    begin
                        drive_dir_next    = DIR_STOP;
                        last_encoder_next = !goal_data_reg.encoder_level;
                        mode_st_next      = ST_REACHED;
                    end
                end
                ST_REACHED:
                begin
                    if (zero_cmd)
                    begin
                        mode_st_next = ST_HOME;
                    end
                end
                ST_HOME:
                begin
                    drive_dir_next   = DIR_DOWN;
                    last_switch_next = goal_data_reg.home_switch_level;
                    // falling edge of the switch: home found
                    if (!goal_data_reg.home_switch_level && last_switch_reg)
                    begin
                        drive_dir_next    = DIR_STOP;
                        mode_st_next      = ST_WAIT;
                        steps_done_next   = 8'd0;
                        target_steps_next = 12'sd0;
                    end
                end
                default:
                begin
                    mode_st_next = ST_HOME;
                end
            endcase
        end
    end

    // result beat from the updated state
    always_comb
    begin
        case (mode_st_next)
            ST_WAIT:    mode_code = MODE_WAIT;
            ST_MOVE:    mode_code = MODE_MOVE;
            ST_REACHED: mode_code = MODE_REACHED;
            ST_HOME:    mode_code = MODE_HOME;
            default:    mode_code = MODE_HOME;
        endcase
        result_next.mode       = mode_code;
        result_next.up_duty    = (drive_dir_next == DIR_UP) ? motor_duty_reg : 8'd0;
        result_next.down_duty  = (drive_dir_next == DIR_DOWN) ? motor_duty_reg : 8'd0;
        result_next.step_count = steps_done_next;
        result_next.goal_count = target_steps_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_st_reg      <= ST_HOME;
            last_encoder_reg <= 1'b0;
            last_switch_reg  <= 1'b1;
            steps_done_reg   <= 8'd0;
            target_steps_reg <= 12'sd0;
            drive_dir_reg    <= DIR_STOP;
        end
        else if (goal_move)
        begin
            mode_st_reg      <= mode_st_next;
            last_encoder_reg <= last_encoder_next;
            last_switch_reg  <= last_switch_next;
            steps_done_reg   <= steps_done_next;
            target_steps_reg <= target_steps_next;
            drive_dir_reg    <= drive_dir_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (goal_move)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = result_reg;

    // waiting always starts from a cleared count and goal
    a_wait_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        mode_st_reg == ST_WAIT |-> steps_done_reg == 8'd0 && target_steps_reg == 12'sd0)
        else $error("count or goal not cleared while waiting");

    // motor is stopped while waiting or after reaching the goal
    a_idle_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.mode == MODE_WAIT || result.mode == MODE_REACHED)
        |-> result.up_duty == 8'd0 && result.down_duty == 8'd0)
        else $error("motor driven while not moving or homing");

    // a beat that finishes the goal stage shows up as a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        goal_move |=> result_valid)
        else $error("result beat lost after state update");

endmodule

`default_nettype wire

[sim/encoder_positioner_with_homing_tb.sv]
`timescale 1ns / 1ps

module encoder_positioner_with_homing_tb;
    import eph_pkg::*;

    localparam int PHASE_TICKS = 230;
    localparam int QUIET_LIMIT = 2000;
    localparam int PIPE_SETTLE = 6;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 60;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic sample_valid;
    logic sample_stall;
    sample_t sample;
    logic result_valid;
    logic result_stall;
    result_t result;

    encoder_positioner_with_homing DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted positioner state and register copies
    logic [1:0] pm_mode;
    dir_t pm_dir;
    logic pm_enc;
    logic pm_sw;
    logic [7:0] pm_steps;
    logic signed [11:0] pm_goal;
    logic [11:0] cfg_hall;
    logic [7:0] cfg_limit;
    logic [7:0] cfg_duty;

    // status beats still owed by the block
    result_t status_due[$];

    // directed plan
    typedef struct {
        sample_t tick;
        bit typed;
        result_t status;
    } plan_row_t;
    plan_row_t plan[$];

    int errors = 0;
    int accepted_ticks = 0;
    int idle_ticks = 0;
    int checked_beats = 0;
    int moves_started = 0;
    int early_stops = 0;
    int homes_found = 0;
    int settings_run = 1;
    int peak_steps = 0;
    int burst_left = 0;

    // goal in steps: round(11 * (v - 360) / 612), half away from zero
    function automatic logic signed [11:0] steps_for_distance(input logic signed [15:0] d);
        int n;
        int mag;
        int q;
        n = 11 * (int'(d) - 360);
        mag = (n < 0) ? -n : n;
        q = (mag + 306) / 612;
        return 12'((n < 0) ? -q : q);
    endfunction

    // one tick of the positioner
    task automatic advance_positioner(input sample_t s, output result_t r);
        logic zero_cmd;
        logic prev_enc;
        logic prev_sw;
        zero_cmd = (s.target_distance == 16'sd0);
        if (!(zero_cmd && pm_mode == MODE_WAIT))
        begin
            prev_enc = pm_enc;
            pm_enc = s.encoder_level;
            case (pm_mode)
                MODE_WAIT:
                begin
                    pm_goal = steps_for_distance(s.target_distance);
                    pm_mode = MODE_MOVE;
                    moves_started++;
                end
                MODE_MOVE:
                begin
                    if (int'(pm_steps) < int'(pm_goal))
                    begin
                        pm_dir = DIR_UP;
                        if (pm_enc && !prev_enc && pm_steps != 8'd255)
                            pm_steps++;
                    end
                    else
                    begin
                        pm_dir = DIR_STOP;
                        pm_mode = MODE_REACHED;
                    end
                    // hall and count checks run even on the goal tick
                    if (s.hall_sample < cfg_hall || pm_steps > cfg_limit)
                    begin
                        pm_dir = DIR_STOP;
                        pm_enc = ~pm_enc;
                        pm_mode = MODE_REACHED;
                        early_stops++;
                    end
                end
                MODE_REACHED:
                begin
                    if (zero_cmd)
                        pm_mode = MODE_HOME;
                end
                default:
                begin
                    prev_sw = pm_sw;
                    pm_dir = DIR_DOWN;
                    pm_sw = s.home_switch_level;
                    if (!pm_sw && prev_sw)
                    begin
                        pm_dir = DIR_STOP;
                        pm_mode = MODE_WAIT;
                        pm_steps = 8'd0;
                        pm_goal = 12'sd0;
                        homes_found++;
                    end
                end
            endcase
        end
        if (int'(pm_steps) > peak_steps)
            peak_steps = pm_steps;
        r.mode = pm_mode;
        r.up_duty = (pm_dir == DIR_UP) ? cfg_duty : 8'd0;
        r.down_duty = (pm_dir == DIR_DOWN) ? cfg_duty : 8'd0;
        r.step_count = pm_steps;
        r.goal_count = pm_goal;
    endtask

    // directed row builder
    function automatic void add_row(input logic signed [15:0] d, input logic enc,
                                    input logic sw, input logic [11:0] hall, input bit typed,
                                    input logic [1:0] m, input logic [7:0] up,
                                    input logic [7:0] dn, input logic [7:0] steps,
                                    input logic signed [11:0] goal);
        plan_row_t row;
        row.tick.target_distance = d;
        row.tick.encoder_level = enc;
        row.tick.home_switch_level = sw;
        row.tick.hall_sample = hall;
        row.typed = typed;
        row.status.mode = m;
        row.status.up_duty = up;
        row.status.down_duty = dn;
        row.status.step_count = steps;
        row.status.goal_count = goal;
        plan.push_back(row);
    endfunction

    // random tick shaped by the predicted mode
    function automatic sample_t make_tick();
        sample_t s;
        int pick;
        s.target_distance = 16'($urandom);
        s.encoder_level = 1'($urandom);
        s.home_switch_level = 1'($urandom);
        s.hall_sample = 12'($urandom);
        // some pure noise
        if ($urandom_range(99) < 8)
            return s;
        pick = $urandom_range(99);
        case (pm_mode)
            MODE_WAIT:
            begin
                if (pick < 12)
                    s.target_distance = 16'sd0;
                else if (pick < 80)
                    s.target_distance = 16'(360 + $urandom_range(2400));
                else if (pick < 94)
                    s.target_distance = 16'(int'($urandom_range(800)) - 400);
            end
            MODE_MOVE:
            begin
                s.encoder_level = (pick < 65) ? ~pm_enc : pm_enc;
                if (cfg_hall != 12'd0 && $urandom_range(99) < 3)
                    s.hall_sample = 12'($urandom_range(cfg_hall - 1));
                else
                    s.hall_sample = 12'($urandom_range(4095, cfg_hall));
            end
            MODE_REACHED:
            begin
                if (pick < 35)
                    s.target_distance = 16'sd0;
            end
            default:
            begin
                if (pm_sw)
                    s.home_switch_level = (pick >= 25);
                else
                    s.home_switch_level = (pick < 70);
                if ($urandom_range(1) == 0)
                    s.target_distance = 16'sd0;
            end
        endcase
        return s;
    endfunction

    // offer one beat in bursts, predict on acceptance
    task automatic offer_tick(input sample_t s, input bit typed, input result_t status);
        int gap;
        result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(40, 1);
            repeat (gap)
            begin
                @(negedge clk);
                sample_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        sample_valid <= 1'b1;
        sample <= s;
        do
            @(posedge clk);
        while (sample_stall);
        if (s.target_distance == 16'sd0 && pm_mode == MODE_WAIT)
            idle_ticks++;
        accepted_ticks++;
        advance_positioner(s, predicted);
        status_due.push_back(typed ? status : predicted);
    endtask

    // stop offering and let every owed beat come out
    task automatic settle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (status_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_HALL_THRESHOLD: cfg_hall = val;
            REG_STEP_LIMIT: cfg_limit = val[7:0];
            REG_MOTOR_DUTY: cfg_duty = val[7:0];
            default: ;
        endcase
    endtask

    task automatic run_random(input int count);
        int busy_ticks;
        sample_t s;
        busy_ticks = 0;
        while (busy_ticks < count)
        begin
            s = make_tick();
            if (!(s.target_distance == 16'sd0 && pm_mode == MODE_WAIT))
                busy_ticks++;
            offer_tick(s, 1'b0, '0);
        end
    endtask

    // output check against the oldest owed beat
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (status_due.size() == 0)
            begin
                $error("unexpected status beat: mode %0d steps %0d", result.mode,
                       result.step_count);
                errors++;
            end
            else
            begin
                want = status_due.pop_front();
                checked_beats++;
                if (result.mode !== want.mode)
                begin
                    $error("mode: expected %0d, got %0d", want.mode, result.mode);
                    errors++;
                end
                if (result.up_duty !== want.up_duty)
                begin
                    $error("up_duty: expected %0d, got %0d", want.up_duty, result.up_duty);
                    errors++;
                end
                if (result.down_duty !== want.down_duty)
                begin
                    $error("down_duty: expected %0d, got %0d", want.down_duty,
                           result.down_duty);
                    errors++;
                end
                if (result.step_count !== want.step_count)
                begin
                    $error("step_count: expected %0d, got %0d", want.step_count,
                           result.step_count);
                    errors++;
                end
                if (result.goal_count !== want.goal_count)
                begin
                    $error("goal_count: expected %0d, got %0d", want.goal_count,
                           result.goal_count);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern with one long hold-off
    initial
    begin
        int hold_left;
        int pattern_left;
        int pattern_kind;
        bit hold_done;
        hold_left = 0;
        pattern_left = 0;
        pattern_kind = 0;
        hold_done = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (!hold_done && accepted_ticks >= HOLD_AT)
            begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_kind = $urandom_range(2);
                    pattern_left = $urandom_range(40, 5);
                end
                pattern_left--;
                case (pattern_kind)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(3) == 0);
                    default: result_stall <= 1'($urandom);
                endcase
            end
        end
    end

    // watchdog on cycles with no beat moving
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("encoder_positioner_with_homing_tb: done, errors");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_valid = 1'b0;
        sample = '0;

        pm_mode = MODE_HOME;
        pm_dir = DIR_STOP;
        pm_enc = 1'b0;
        pm_sw = 1'b1;
        pm_steps = 8'd0;
        pm_goal = 12'sd0;
        cfg_hall = HALL_THRESHOLD_RST;
        cfg_limit = STEP_LIMIT_RST;
        cfg_duty = MOTOR_DUTY_RST;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // homing out of reset, then a zero goal move
        add_row(16'sd0, 0, 1, 12'd2000, 1, MODE_HOME, 0, MOTOR_DUTY_RST, 0, 0);
        add_row(16'sd0, 0, 0, 12'd2000, 1, MODE_WAIT, 0, 0, 0, 0);
        add_row(16'sd0, 1, 1, 12'd0, 1, MODE_WAIT, 0, 0, 0, 0);
        add_row(16'sd360, 1, 1, 12'd2000, 1, MODE_MOVE, 0, 0, 0, 0);
        add_row(16'sd0, 0, 1, 12'd2000, 1, MODE_REACHED, 0, 0, 0, 0);
        add_row(16'sd0, 0, 1, 12'd0, 1, MODE_HOME, 0, 0, 0, 0);
        add_row(16'sd0, 0, 1, 12'd0, 1, MODE_HOME, 0, MOTOR_DUTY_RST, 0, 0);
        add_row(16'sd0, 0, 0, 12'd0, 1, MODE_WAIT, 0, 0, 0, 0);
        // largest distance, one step, then a low hall reading
        add_row(16'sd32767, 0, 1, 12'd4095, 1, MODE_MOVE, 0, 0, 0, 12'sd582);
        add_row(16'sd0, 1, 1, 12'd4095, 1, MODE_MOVE, MOTOR_DUTY_RST, 0, 1, 12'sd582);
        add_row(16'sd0, 0, 1, 12'd29, 1, MODE_REACHED, 0, 0, 1, 12'sd582);
        add_row(16'sd0, 1, 0, 12'd0, 1, MODE_HOME, 0, 0, 1, 12'sd582);
        // switch already low is no falling edge
        add_row(16'sd0, 0, 0, 12'd0, 1, MODE_HOME, 0, MOTOR_DUTY_RST, 1, 12'sd582);
        add_row(16'sd0, 0, 1, 12'd0, 1, MODE_HOME, 0, MOTOR_DUTY_RST, 1, 12'sd582);
        add_row(16'sd0, 0, 0, 12'd0, 1, MODE_WAIT, 0, 0, 0, 0);
        // most negative distance, hall exactly at threshold
        add_row(-16'sd32768, 0, 1, 12'd30, 1, MODE_MOVE, 0, 0, 0, -12'sd595);
        add_row(16'sd0, 1, 1, 12'd30, 1, MODE_REACHED, 0, 0, 0, -12'sd595);
        add_row(16'sd0, 1, 1, 12'd0, 1, MODE_HOME, 0, 0, 0, -12'sd595);
        add_row(16'sd0, 1, 1, 12'd0, 1, MODE_HOME, 0, MOTOR_DUTY_RST, 0, -12'sd595);
        add_row(16'sd0, 0, 0, 12'd0, 1, MODE_WAIT, 0, 0, 0, 0);
        // halfway roundings, negative then positive
        add_row(16'sd54, 0, 1, 12'd500, 0, 0, 0, 0, 0, 0);
        add_row(16'sd0, 1, 1, 12'd500, 0, 0, 0, 0, 0, 0);
        add_row(16'sd0, 0, 1, 12'd500, 0, 0, 0, 0, 0, 0);
        add_row(16'sd0, 0, 1, 12'd500, 0, 0, 0, 0, 0, 0);
        add_row(16'sd0, 0, 0, 12'd500, 0, 0, 0, 0, 0, 0);
        add_row(16'sd666, 1, 1, 12'd500, 0, 0, 0, 0, 0, 0);

        foreach (plan[i])
            offer_tick(plan[i].tick, plan[i].typed, plan[i].status);

        // widest settings, unused index must be ignored
        settle();
        write_reg(REG_HALL_THRESHOLD, 12'd0);
        write_reg(REG_STEP_LIMIT, 12'd254);
        write_reg(REG_MOTOR_DUTY, 12'd255);
        write_reg(REG_UNUSED, 12'hFFF);
        settings_run++;
        run_random(PHASE_TICKS);

        // tightest settings
        settle();
        write_reg(REG_HALL_THRESHOLD, 12'd4095);
        write_reg(REG_STEP_LIMIT, 12'd0);
        write_reg(REG_MOTOR_DUTY, 12'd0);
        settings_run++;
        run_random(PHASE_TICKS);

        // two random settings
        repeat (2)
        begin
            settle();
            write_reg(REG_HALL_THRESHOLD, 12'($urandom_range(600)));
            write_reg(REG_STEP_LIMIT, 12'($urandom_range(254)));
            write_reg(REG_MOTOR_DUTY, 12'($urandom_range(255)));
            settings_run++;
            run_random(PHASE_TICKS);
        end

        settle();
        $display("run covered %0d ticks (%0d idle) over %0d register settings, %0d beats checked",
                 accepted_ticks, idle_ticks, settings_run, checked_beats);
        $display("moves %0d, early stops %0d, homing returns %0d, peak step count %0d",
                 moves_started, early_stops, homes_found, peak_steps);
        if (errors == 0)
            $display("encoder_positioner_with_homing_tb: done, clean");
        else
            $display("encoder_positioner_with_homing_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
design/eph_pkg.sv
design/encoder_positioner_with_homing.sv
sim/encoder_positioner_with_homing_tb.sv
